@@ hdl/bartc_pkg.sv @@
package bartc_pkg;

    typedef struct packed {
        logic [19:0] raw_pressure;
        logic [19:0] raw_temperature;
    } sample_t;

    typedef struct packed {
        logic signed [27:0] temp_centi;
        logic [31:0]        pressure_q8;
        logic [1:0]         status;
    } result_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_SKIPPED  = 2'd1,
        ST_ZERO_DIV = 2'd2,
        ST_RANGE    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CFG_TEMP_TRIM  = 2'd0,
        CFG_PRESS_LOW  = 2'd1,
        CFG_PRESS_HIGH = 2'd2,
        CFG_PRESS_LAST = 2'd3
    } cfg_index_t;

    localparam logic [19:0] MARKER        = 20'h80000;
    localparam int          T_FINE_OFFSET = 128000;
    localparam int          P_SCALE       = 3125;
    localparam logic [20:0] P_BASE        = 21'h100000;
    localparam logic [31:0] P_LOW_Q8      = 32'd7680000;
    localparam logic [31:0] P_HIGH_Q8     = 32'd30720000;

    localparam int QBITS       = 39;
    localparam int PRE_STAGES  = 10;
    localparam int POST_STAGES = 5;
    localparam int LATENCY     = PRE_STAGES + QBITS + POST_STAGES;

    typedef struct packed {
        logic               neg;
        logic               ovf;
        logic               skipped;
        logic               zero_div;
        logic signed [20:0] tc;
    } side_t;

endpackage

@@ hdl/bartc_div.sv @@
module bartc_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_vld,
    input  logic [63:0]                    rem_in,
    input  logic [bartc_pkg::QBITS-1:0]    low_in,
    input  logic [63:0]                    dabs_in,
    input  bartc_pkg::side_t               side_in,
    output logic                           out_vld,
    output logic [bartc_pkg::QBITS-1:0]    quot,
    output bartc_pkg::side_t               side_out
);
    import bartc_pkg::*;

    logic [QBITS:1]      vld_reg;
    logic [63:0]         rem_reg  [1:QBITS];
    logic [QBITS-1:0]    low_reg  [1:QBITS];
    logic [QBITS-1:0]    quot_reg [1:QBITS];
    logic [63:0]         dabs_reg [1:QBITS];
    side_t               side_reg [1:QBITS];

    genvar k;
    generate
        for (k = 0; k < QBITS; k++)
        begin : g_step
            logic [63:0]      rem_i;
            logic [QBITS-1:0] low_i;
            logic [QBITS-1:0] quot_i;
            logic [63:0]      dabs_i;
            side_t            side_i;
            logic             vld_i;
            logic [64:0]      cand;
            logic             ge;

            if (k == 0)
            begin : g_head
                assign rem_i  = rem_in;
                assign low_i  = low_in;
                assign quot_i = '0;
                assign dabs_i = dabs_in;
                assign side_i = side_in;
                assign vld_i  = in_vld;
            end
            else
            begin : g_body
                assign rem_i  = rem_reg[k];
                assign low_i  = low_reg[k];
                assign quot_i = quot_reg[k];
                assign dabs_i = dabs_reg[k];
                assign side_i = side_reg[k];
                assign vld_i  = vld_reg[k];
            end

            assign cand = {rem_i, low_i[QBITS-1]};
            assign ge   = cand >= {1'b0, dabs_i};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k+1] <= 1'b0;
                end
                else
                begin
                    vld_reg[k+1] <= vld_i;
                end
            end

            always_ff @(posedge clk)
            begin
                rem_reg[k+1]  <= ge ? 64'(cand - {1'b0, dabs_i}) : cand[63:0];
                low_reg[k+1]  <= {low_i[QBITS-2:0], 1'b0};
                quot_reg[k+1] <= {quot_i[QBITS-2:0], ge};
                dabs_reg[k+1] <= dabs_i;
                side_reg[k+1] <= side_i;
            end
        end
    endgenerate

    assign out_vld  = vld_reg[QBITS];
    assign quot     = quot_reg[QBITS];
    assign side_out = side_reg[QBITS];

endmodule

@@ hdl/baro_trim_compensation.sv @@
// Channel  | Ports                                 | Handshake
// request  | start, busy, sample                   | taken when start high and busy low
// config   | cfg_we, cfg_index, cfg_data           | written when cfg_we high
// result   | done, result                          | one-cycle strobe, cannot be held off
// One request per cycle; busy stays low.
// Pipeline: 10 trim and product stages, 39 divider stages (one quotient
// bit each), 5 correction and output stages.
// Reset clears valid bits and trim registers; no request is lost or repeated.
module baro_trim_compensation (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  bartc_pkg::sample_t  sample,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [63:0]         cfg_data,
    output logic                done,
    output bartc_pkg::result_t  result
);
    import bartc_pkg::*;

    logic [47:0] temp_trim_reg;
    logic [63:0] press_low_reg;
    logic [63:0] press_high_reg;
    logic [15:0] press_last_reg;

    logic [15:0]        t1, p1;
    logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;

    assign t1 = temp_trim_reg[15:0];
    assign t2 = $signed(temp_trim_reg[31:16]);
    assign t3 = $signed(temp_trim_reg[47:32]);
    assign p1 = press_low_reg[15:0];
    assign p2 = $signed(press_low_reg[31:16]);
    assign p3 = $signed(press_low_reg[47:32]);
    assign p4 = $signed(press_low_reg[63:48]);
    assign p5 = $signed(press_high_reg[15:0]);
    assign p6 = $signed(press_high_reg[31:16]);
    assign p7 = $signed(press_high_reg[47:32]);
    assign p8 = $signed(press_high_reg[63:48]);
    assign p9 = $signed(press_last_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_trim_reg  <= '0;
            press_low_reg  <= '0;
            press_high_reg <= '0;
            press_last_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TEMP_TRIM:  temp_trim_reg  <= cfg_data[47:0];
                CFG_PRESS_LOW:  press_low_reg  <= cfg_data;
                CFG_PRESS_HIGH: press_high_reg <= cfg_data;
                CFG_PRESS_LAST: press_last_reg <= cfg_data[15:0];
                default:        press_last_reg <= press_last_reg;
            endcase
        end
    end

    logic                    take;
    logic [PRE_STAGES-1:0]   vld_reg;
    logic [PRE_STAGES-1:0]   vld_next;

    assign busy     = 1'b0;
    assign take     = start && !busy;
    assign vld_next = {vld_reg[PRE_STAGES-2:0], take};

    // stage registers
    logic [19:0]        rp1_reg, rp2_reg, rp3_reg, rp4_reg, rp5_reg, rp6_reg, rp7_reg;
    logic               mk1_reg, mk2_reg, mk3_reg, mk4_reg, mk5_reg, mk6_reg, mk7_reg;
    logic               mk8_reg, mk9_reg, mk10_reg;
    logic signed [17:0] a1_reg;
    logic signed [16:0] b1_reg;
    logic signed [33:0] at2_reg, bb2_reg;
    logic signed [24:0] tf3_reg;
    logic signed [20:0] tc4_reg, tc5_reg, tc6_reg, tc7_reg, tc8_reg, tc9_reg, tc10_reg;
    logic signed [25:0] v14_reg;
    logic signed [51:0] vv5_reg;
    logic signed [41:0] v1p5_5_reg, v1p2_5_reg, v1p5_6_reg, v1p2_6_reg;
    logic signed [63:0] w6_6_reg, w3_6_reg;
    logic signed [63:0] v2_7_reg, v1b_7_reg;
    logic signed [63:0] d8_reg, x8_reg, d9_reg;
    logic signed [76:0] n9_reg;
    logic               zero9_reg, zero10_reg;
    logic [75:0]        nabs10_reg;
    logic [63:0]        dabs10_reg;
    logic               neg10_reg, ovf10_reg;

    // stage 3 and 4 logic
    logic signed [37:0] bbt3;
    logic signed [24:0] tf_next;
    logic signed [28:0] tf5;
    assign bbt3    = $signed(bb2_reg[33:12]) * t3;
    assign tf_next = $signed(at2_reg[33:11]) + $signed(bbt3[37:14]);
    assign tf5     = tf3_reg * 29'sd5 + 29'sd128;

    // stage 6 to 8 logic
    logic signed [67:0] w6p, w3p;
    logic signed [63:0] v1p5x, v1p2x, p4x, base;
    logic signed [80:0] m8;
    logic [20:0]        pb;
    logic [63:0]        xh;
    assign w6p   = vv5_reg * p6;
    assign w3p   = vv5_reg * p3;
    assign v1p5x = v1p5_6_reg;
    assign v1p2x = v1p2_6_reg;
    assign p4x   = p4;
    assign base  = v1b_7_reg + 64'sh0000_8000_0000_0000;
    assign m8    = base * $signed({1'b0, p1});
    assign pb    = P_BASE - {1'b0, rp7_reg};
    assign xh    = {12'b0, pb, 31'b0};

    logic signed [76:0] nneg;
    logic [63:0]        dneg;
    logic [75:0]        nabs_next;
    logic [63:0]        dabs_next;
    assign nneg      = -n9_reg;
    assign dneg      = 64'(-d9_reg);
    assign nabs_next = n9_reg[76] ? nneg[75:0] : n9_reg[75:0];
    assign dabs_next = d9_reg[63] ? dneg : d9_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rp1_reg  <= sample.raw_pressure;
        mk1_reg  <= (sample.raw_pressure == MARKER) || (sample.raw_temperature == MARKER);
        a1_reg   <= $signed({1'b0, sample.raw_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
        b1_reg   <= $signed({1'b0, sample.raw_temperature[19:4]}) - $signed({1'b0, t1});

        rp2_reg  <= rp1_reg;
        mk2_reg  <= mk1_reg;
        at2_reg  <= a1_reg * t2;
        bb2_reg  <= b1_reg * b1_reg;

        rp3_reg  <= rp2_reg;
        mk3_reg  <= mk2_reg;
        tf3_reg  <= tf_next;

        rp4_reg  <= rp3_reg;
        mk4_reg  <= mk3_reg;
        tc4_reg  <= tf5[28:8];
        v14_reg  <= tf3_reg - 26'sd128000;

        rp5_reg    <= rp4_reg;
        mk5_reg    <= mk4_reg;
        tc5_reg    <= tc4_reg;
        vv5_reg    <= v14_reg * v14_reg;
        v1p5_5_reg <= v14_reg * p5;
        v1p2_5_reg <= v14_reg * p2;

        rp6_reg    <= rp5_reg;
        mk6_reg    <= mk5_reg;
        tc6_reg    <= tc5_reg;
        w6_6_reg   <= w6p[63:0];
        w3_6_reg   <= w3p[63:0];
        v1p5_6_reg <= v1p5_5_reg;
        v1p2_6_reg <= v1p2_5_reg;

        rp7_reg   <= rp6_reg;
        mk7_reg   <= mk6_reg;
        tc7_reg   <= tc6_reg;
        v2_7_reg  <= w6_6_reg + (v1p5x <<< 17) + (p4x <<< 35);
        v1b_7_reg <= $signed(w3_6_reg[63:8]) + (v1p2x <<< 12);

        mk8_reg  <= mk7_reg;
        tc8_reg  <= tc7_reg;
        d8_reg   <= $signed({{16{m8[80]}}, m8[80:33]});
        x8_reg   <= $signed(xh) - v2_7_reg;

        mk9_reg   <= mk8_reg;
        tc9_reg   <= tc8_reg;
        zero9_reg <= (d8_reg == 64'sd0);
        d9_reg    <= d8_reg;
        n9_reg    <= x8_reg * 13'sd3125;

        mk10_reg   <= mk9_reg;
        tc10_reg   <= tc9_reg;
        zero10_reg <= zero9_reg;
        nabs10_reg <= nabs_next;
        dabs10_reg <= dabs_next;
        neg10_reg  <= n9_reg[76] ^ d9_reg[63];
        ovf10_reg  <= {27'b0, nabs_next[75:39]} >= dabs_next;
    end

    side_t            side_in, side_q;
    logic             dv;
    logic [QBITS-1:0] qm;

    assign side_in = '{neg: neg10_reg, ovf: ovf10_reg, skipped: mk10_reg,
                       zero_div: zero10_reg, tc: tc10_reg};

    bartc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (vld_reg[PRE_STAGES-1]),
        .rem_in   ({27'b0, nabs10_reg[75:39]}),
        .low_in   (nabs10_reg[QBITS-1:0]),
        .dabs_in  (dabs10_reg),
        .side_in  (side_in),
        .out_vld  (dv),
        .quot     (qm),
        .side_out (side_q)
    );

    // correction stages
    logic [POST_STAGES-1:0] pv_reg;
    side_t                  ps1_reg, ps2_reg, ps3_reg, ps4_reg;
    logic signed [38:0]     q1_reg, q2_reg, q3_reg;
    logic signed [25:0]     s2_reg;
    logic signed [41:0]     p9s2_reg;
    logic signed [54:0]     p8q2_reg, p8q3_reg;
    logic signed [63:0]     p9ss3_reg;
    logic signed [63:0]     pf4_reg;
    result_t                res_reg;

    logic [QBITS-1:0]   lim, qsat;
    logic signed [38:0] q_next;
    logic signed [67:0] p9ssp;
    logic signed [63:0] qx, p7x, sum4;
    logic signed [25:0] s_next;
    result_t            res_next;

    assign lim    = side_q.neg ? 39'h20_0000_0000 : 39'h1F_FFFF_FFFF;
    assign qsat   = (side_q.ovf || (qm > lim)) ? lim : qm;
    assign q_next = side_q.neg ? -$signed(qsat) : $signed(qsat);
    assign s_next = q1_reg[38:13];
    assign p9ssp  = p9s2_reg * s2_reg;
    assign qx     = q3_reg;
    assign p7x    = p7;
    assign sum4   = qx + $signed(p9ss3_reg[63:25]) + $signed(p8q3_reg[54:19]);

    always_comb
    begin
        res_next.temp_centi  = 28'(ps4_reg.tc);
        res_next.pressure_q8 = 32'(pf4_reg);
        res_next.status      = ST_OK;
        if (pf4_reg[63])
        begin
            res_next.pressure_q8 = '0;
        end
        else if (pf4_reg[62:32] != '0)
        begin
            res_next.pressure_q8 = '1;
        end
        if (pf4_reg[63] || (pf4_reg < 64'sd7680000) || (pf4_reg > 64'sd30720000))
        begin
            res_next.status = ST_RANGE;
        end
        if (ps4_reg.skipped)
        begin
            res_next.temp_centi  = '0;
            res_next.pressure_q8 = '0;
            res_next.status      = ST_SKIPPED;
        end
        else if (ps4_reg.zero_div)
        begin
            res_next.pressure_q8 = '0;
            res_next.status      = ST_ZERO_DIV;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= '0;
        end
        else
        begin
            pv_reg <= {pv_reg[POST_STAGES-2:0], dv};
        end
    end

    always_ff @(posedge clk)
    begin
        ps1_reg   <= side_q;
        q1_reg    <= q_next;

        ps2_reg   <= ps1_reg;
        q2_reg    <= q1_reg;
        s2_reg    <= s_next;
        p9s2_reg  <= p9 * s_next;
        p8q2_reg  <= p8 * q1_reg;

        ps3_reg   <= ps2_reg;
        q3_reg    <= q2_reg;
        p8q3_reg  <= p8q2_reg;
        p9ss3_reg <= p9ssp[63:0];

        ps4_reg   <= ps3_reg;
        pf4_reg   <= $signed(sum4[63:8]) + (p7x <<< 4);

        res_reg   <= res_next;
    end

    assign done   = pv_reg[POST_STAGES-1];
    assign result = res_reg;

endmodule

@@ hdl/bartc_checker.sv @@
module bartc_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input bartc_pkg::result_t result
);
    import bartc_pkg::*;

    assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n, LATENCY) |-> (done == $past(start && !busy, LATENCY)))
        else $error("result strobe does not follow request");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status == ST_SKIPPED)) |->
        ((result.temp_centi == '0) && (result.pressure_q8 == '0)))
        else $error("skipped reading carries data");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status == ST_ZERO_DIV)) |-> (result.pressure_q8 == '0))
        else $error("zero divisor carries pressure");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status == ST_OK)) |->
        ((result.pressure_q8 >= P_LOW_Q8) && (result.pressure_q8 <= P_HIGH_Q8)))
        else $error("pressure out of range marked ok");

endmodule

bind baro_trim_compensation bartc_checker u_bartc_checker (.*);

@@ sim/baro_trim_compensation_tb.sv @@
module baro_trim_compensation_tb;
    import bartc_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    sample_t     sample;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        done;
    result_t     result;

    logic [47:0] trim_t;
    logic [63:0] trim_pl;
    logic [63:0] trim_ph;
    logic [15:0] trim_p9;

    result_t pending_results[$];
    int      mismatch_count;
    int      spurious_count;
    bit      allow_idle;

    baro_trim_compensation uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .sample    (sample),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .done      (done),
        .result    (result)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic result_t compensate(logic [19:0] rp, logic [19:0] rt);
        logic signed [63:0]  t1;
        logic signed [63:0]  t2;
        logic signed [63:0]  t3;
        logic signed [63:0]  p1;
        logic signed [63:0]  p2;
        logic signed [63:0]  p3;
        logic signed [63:0]  p4;
        logic signed [63:0]  p5;
        logic signed [63:0]  p6;
        logic signed [63:0]  p7;
        logic signed [63:0]  p8;
        logic signed [63:0]  p9;
        logic signed [63:0]  a;
        logic signed [63:0]  b;
        logic signed [63:0]  tf;
        logic signed [63:0]  tc;
        logic signed [63:0]  v1;
        logic signed [63:0]  v2;
        logic signed [63:0]  d;
        logic signed [63:0]  x;
        logic signed [63:0]  q;
        logic signed [63:0]  s;
        logic signed [63:0]  pf;
        logic signed [127:0] m;
        logic signed [127:0] num;
        logic signed [127:0] quo;
        logic signed [127:0] qlim;
        result_t r;
        begin
            r = '0;
            if (rp == MARKER || rt == MARKER)
            begin
                r.status = ST_SKIPPED;
                return r;
            end
            t1 = {48'd0, trim_t[15:0]};
            t2 = {{48{trim_t[31]}}, trim_t[31:16]};
            t3 = {{48{trim_t[47]}}, trim_t[47:32]};
            p1 = {48'd0, trim_pl[15:0]};
            p2 = {{48{trim_pl[31]}}, trim_pl[31:16]};
            p3 = {{48{trim_pl[47]}}, trim_pl[47:32]};
            p4 = {{48{trim_pl[63]}}, trim_pl[63:48]};
            p5 = {{48{trim_ph[15]}}, trim_ph[15:0]};
            p6 = {{48{trim_ph[31]}}, trim_ph[31:16]};
            p7 = {{48{trim_ph[47]}}, trim_ph[47:32]};
            p8 = {{48{trim_ph[63]}}, trim_ph[63:48]};
            p9 = {{48{trim_p9[15]}}, trim_p9};
            a  = $signed({44'd0, rt} >>> 3) - (t1 <<< 1);
            b  = $signed({44'd0, rt} >>> 4) - t1;
            tf = ((a * t2) >>> 11) + ((((b * b) >>> 12) * t3) >>> 14);
            tc = (tf * 5 + 128) >>> 8;
            r.temp_centi = tc[27:0];
            v1 = tf - 64'sd128000;
            v2 = v1 * v1 * p6 + ((v1 * p5) <<< 17) + (p4 <<< 35);
            v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
            m  = 128'(signed'((64'sd1 <<< 47) + v1)) * 128'(p1);
            d  = m[96:33];
            if (d == 0)
            begin
                r.status = ST_ZERO_DIV;
                return r;
            end
            x    = ((64'sd1048576 - $signed({44'd0, rp})) <<< 31) - v2;
            num  = 128'(x) * 128'sd3125;
            quo  = num / 128'(d);
            qlim = 128'sd1 <<< 37;
            if (quo > qlim - 1)
                q = 64'(qlim - 1);
            else if (quo < -qlim)
                q = -64'(qlim);
            else
                q = 64'(quo);
            s  = q >>> 13;
            pf = ((q + ((p9 * s * s) >>> 25) + ((p8 * q) >>> 19)) >>> 8) + (p7 <<< 4);
            if (pf < 0)
                r.pressure_q8 = '0;
            else if (pf > 64'sd4294967295)
                r.pressure_q8 = '1;
            else
                r.pressure_q8 = pf[31:0];
            if (pf < 64'sd7680000 || pf > 64'sd30720000)
                r.status = ST_RANGE;
            else
                r.status = ST_OK;
            return r;
        end
    endfunction

    task automatic idle_burst();
        int n;
        begin
            n = $urandom_range(1, 7);
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic send_reading(logic [19:0] rp, logic [19:0] rt);
        begin
            if (allow_idle && $urandom_range(0, 5) == 0)
            begin
                start <= 1'b0;
                idle_burst();
            end
            start  <= 1'b1;
            sample <= '{raw_pressure: rp, raw_temperature: rt};
            @(posedge clk);
            while (busy)
                @(posedge clk);
            pending_results.push_back(compensate(rp, rt));
        end
    endtask

    task automatic drain();
        int guard;
        begin
            start <= 1'b0;
            guard = 0;
            while (pending_results.size() != 0 && guard < 10000)
            begin
                @(posedge clk);
                guard++;
            end
            repeat (LATENCY + 10) @(posedge clk);
        end
    endtask

    task automatic write_trim(cfg_index_t idx, logic [63:0] value);
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= value;
            @(posedge clk);
            cfg_we    <= 1'b0;
            case (idx)
                CFG_TEMP_TRIM:  trim_t  = value[47:0];
                CFG_PRESS_LOW:  trim_pl = value;
                CFG_PRESS_HIGH: trim_ph = value;
                default:        trim_p9 = value[15:0];
            endcase
            @(posedge clk);
        end
    endtask

    task automatic load_typical();
        begin
            write_trim(CFG_TEMP_TRIM,  {16'hFC18, 16'd26435, 16'd27504});
            write_trim(CFG_PRESS_LOW,  {16'd2855, 16'd8192, 16'hD4BC, 16'd36477});
            write_trim(CFG_PRESS_HIGH, {16'hF70A, 16'd15500, 16'hFFF9, 16'd140});
            write_trim(CFG_PRESS_LAST, 64'd6000);
        end
    endtask

    function automatic logic [19:0] pick_raw();
        case ($urandom_range(0, 9))
            0:       return MARKER;
            1:       return 20'h00000;
            2:       return 20'hFFFFF;
            3:       return 20'($urandom);
            default: return 20'($urandom_range(300000, 700000));
        endcase
    endfunction

    task automatic test_reset_trims();
        begin
            send_reading(20'd415148, 20'd519888);
            send_reading(20'hFFFFF, 20'h00000);
            drain();
        end
    endtask

    task automatic test_directed();
        begin
            load_typical();
            send_reading(20'd415148, 20'd519888);
            send_reading(20'd300000, 20'd500000);
            send_reading(MARKER, 20'd519888);
            send_reading(20'd415148, MARKER);
            send_reading(MARKER, MARKER);
            send_reading(20'h00000, 20'h00000);
            send_reading(20'hFFFFF, 20'hFFFFF);
            send_reading(20'h00000, 20'hFFFFF);
            send_reading(20'hFFFFF, 20'h00000);
            send_reading(20'h7FFFF, 20'h80001);
            send_reading(20'd900000, 20'd519888);
            send_reading(20'd100000, 20'd519888);
            drain();
            write_trim(CFG_PRESS_LOW, {48'h0, 16'h0000});
            send_reading(20'd415148, 20'd519888);
            send_reading(20'd0, 20'd0);
            drain();
        end
    endtask

    task automatic test_extreme_trims();
        int k;
        begin
            write_trim(CFG_TEMP_TRIM,  64'h7FFF_8000_FFFF);
            write_trim(CFG_PRESS_LOW,  64'h8000_7FFF_8000_FFFF);
            write_trim(CFG_PRESS_HIGH, 64'h7FFF_8000_7FFF_8000);
            write_trim(CFG_PRESS_LAST, 64'hFFFF_FFFF_FFFF_8000);
            for (k = 0; k < 10; k++)
                send_reading(pick_raw(), pick_raw());
            drain();
            write_trim(CFG_TEMP_TRIM,  64'hFFFF_FFFF_FFFF_FFFF);
            write_trim(CFG_PRESS_LOW,  64'hFFFF_FFFF_FFFF_FFFF);
            write_trim(CFG_PRESS_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
            write_trim(CFG_PRESS_LAST, 64'h7FFF);
            for (k = 0; k < 10; k++)
                send_reading(pick_raw(), pick_raw());
            drain();
        end
    endtask

    task automatic test_random_trims(int phases, int per_phase);
        int ph;
        int k;
        begin
            for (ph = 0; ph < phases; ph++)
            begin
                if (ph % 2 == 0)
                begin
                    load_typical();
                    write_trim(CFG_PRESS_HIGH, {trim_ph[63:32], 32'($urandom)});
                    write_trim(CFG_TEMP_TRIM, {trim_t[47:16], 16'($urandom_range(20000, 32000))});
                end
                else
                begin
                    write_trim(CFG_TEMP_TRIM,  {$urandom, $urandom});
                    write_trim(CFG_PRESS_LOW,  {$urandom, $urandom});
                    write_trim(CFG_PRESS_HIGH, {$urandom, $urandom});
                    write_trim(CFG_PRESS_LAST, {$urandom, $urandom});
                end
                for (k = 0; k < per_phase; k++)
                    send_reading(pick_raw(), pick_raw());
                drain();
            end
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                spurious_count++;
                if (spurious_count + mismatch_count <= 10)
                    $display("unexpected result %h", result);
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.temp_centi !== want.temp_centi
                    || result.pressure_q8 !== want.pressure_q8
                    || result.status !== want.status)
                begin
                    mismatch_count++;
                    if (spurious_count + mismatch_count <= 10)
                        $display("mismatch: want t=%0d p=%0d s=%0d got t=%0d p=%0d s=%0d",
                                 want.temp_centi, want.pressure_q8, want.status,
                                 result.temp_centi, result.pressure_q8, result.status);
                end
            end
        end
    end

    initial
    begin
        #5000000;
        $display("FAIL baro_trim_compensation");
        $finish;
    end

    initial
    begin
        rst_n          = 1'b0;
        start          = 1'b0;
        sample         = '0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        trim_t         = '0;
        trim_pl        = '0;
        trim_ph        = '0;
        trim_p9        = '0;
        mismatch_count = 0;
        spurious_count = 0;
        allow_idle     = 1'b1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_trims();
        test_directed();
        test_extreme_trims();
        test_random_trims(10, 50);
        allow_idle = 1'b0;
        test_random_trims(2, 30);
        if (mismatch_count == 0 && spurious_count == 0 && pending_results.size() == 0)
            $display("PASS baro_trim_compensation");
        else
            $display("FAIL baro_trim_compensation");
        $finish;
    end

endmodule

@@ baro_trim_compensation.f @@
hdl/bartc_pkg.sv
hdl/bartc_div.sv
hdl/baro_trim_compensation.sv
hdl/bartc_checker.sv
sim/baro_trim_compensation_tb.sv
